[rtl/core/aasc_pkg.sv]
package aasc_pkg;

  localparam int RawW     = 14;
  localparam int AngW     = 17;
  localparam int AngExtW  = 19;
  localparam int CoordW   = 16;
  localparam int DeltaW   = 17;
  localparam int FsW      = 13;
  localparam int LenW     = 14;
  localparam int FaultW   = 2;
  localparam int LimW     = 18;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 17;

  // CORDIC datapath widths: vector components and angle in degrees * 2^16.
  localparam int CordW    = 32;
  localparam int ZW       = 27;
  localparam int AtanLen  = 24;

  // Long division widths for the two scaling steps.
  localparam int Div0NumW = 30;
  localparam int Div0DenW = FsW;
  localparam int Div1DenW = 17;
  localparam int Div1QuoW = FsW;
  localparam int Div1NumW = 30;

  localparam logic signed [ZW-1:0] Deg90  = 27'sd5898240;
  localparam logic signed [ZW-1:0] Deg180 = 27'sd11796480;
  localparam logic signed [ZW-1:0] Deg360 = 27'sd23592960;
  localparam logic [29:0]          GainQ30 = 30'd652032874;

  typedef enum logic [CfgAddrW-1:0] {
    REG_FULL_SCALE = 3'd0,
    REG_ANGLE_LOW  = 3'd1,
    REG_ANGLE_HIGH = 3'd2,
    REG_CENTER_X   = 3'd3,
    REG_CENTER_Y   = 3'd4,
    REG_ARM_LENGTH = 3'd5
  } cfg_reg_e;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2
  } fault_e;

  typedef enum logic {
    OP_TO_POS   = 1'b0,
    OP_TO_ANGLE = 1'b1
  } op_e;

  // Per-word sideband that travels along every cell of the pipeline.
  typedef struct packed {
    op_e                        op;
    logic signed [RawW-1:0]     raw;
    fault_e                     fault;
    logic [CoordW-1:0]          px;
    logic [CoordW-1:0]          py;
    logic signed [DeltaW-1:0]   dx;
    logic signed [DeltaW-1:0]   dy;
    logic                       neg;
    logic                       flip;
    logic                       zero;
    logic                       dz;
    logic signed [AngExtW-1:0]  ang;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117305;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/arm_angle_sensor_converter.sv]
// Channel  | Direction | Word
// s_axis   | in        | tuser: opcode; tdata: raw_sample, coord_x, coord_y
// m_axis   | out       | tdata: raw_value, angle_out, pos_x, pos_y, fault
// cfg      | in        | write enable, register index, data
//
// One word enters per cycle while the output is not stalled; each result passes through
// the two bit-per-cell divider chains (30 and 13 cells), the CORDIC chain and the
// single-register stages around them.
// Reset clears all valid flags and loads the register reset values; no clearing pass.
// A stalled output freezes the whole pipeline, so s_axis_tready follows
// m_axis_tready whenever a result is held in the output register.
module arm_angle_sensor_converter #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [aasc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [aasc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [47:0]                       s_axis_tdata,  // raw_sample, coord_x, coord_y
  input  logic [0:0]                        s_axis_tuser,  // opcode
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [71:0]                       m_axis_tdata   // raw_value, angle_out, pos_x,
                                                           // pos_y, fault
);

  localparam int N0 = aasc_pkg::Div0NumW;
  localparam int N1 = aasc_pkg::Div1QuoW;
  localparam int CW = aasc_pkg::CordW;
  localparam int ZW = aasc_pkg::ZW;
  localparam int AW = aasc_pkg::AngExtW;

  // Configuration registers.
  logic [aasc_pkg::FsW-1:0]            fs_q;
  logic signed [aasc_pkg::AngW-1:0]    lo_q;
  logic [aasc_pkg::CoordW-1:0]         hi_q;
  logic [aasc_pkg::CoordW-1:0]         cx_q, cy_q;
  logic [aasc_pkg::LenW-1:0]           len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= 13'd4095;
      lo_q  <= -17'sd23040;
      hi_q  <= 16'd23040;
      cx_q  <= 16'd6400;
      cy_q  <= 16'd4800;
      len_q <= 14'd1280;
    end else if (cfg_we_i) begin
      case (aasc_pkg::cfg_reg_e'(cfg_addr_i))
        aasc_pkg::REG_FULL_SCALE: fs_q  <= cfg_data_i[12:0];
        aasc_pkg::REG_ANGLE_LOW:  lo_q  <= $signed(cfg_data_i[16:0]);
        aasc_pkg::REG_ANGLE_HIGH: hi_q  <= cfg_data_i[15:0];
        aasc_pkg::REG_CENTER_X:   cx_q  <= cfg_data_i[15:0];
        aasc_pkg::REG_CENTER_Y:   cy_q  <= cfg_data_i[15:0];
        aasc_pkg::REG_ARM_LENGTH: len_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  logic                                en;
  logic                                out_v_q;
  logic signed [aasc_pkg::LimW-1:0]    dlim;
  logic [aasc_pkg::FsW-1:0]            fs_eff;
  logic signed [AW-1:0]                lo_x, hi_x;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign dlim          = $signed({2'b00, hi_q}) - aasc_pkg::LimW'(lo_q);
  assign fs_eff        = (fs_q == '0) ? 13'd1 : fs_q;
  assign lo_x          = AW'(lo_q);
  assign hi_x          = $signed({3'b000, hi_q});

  // Stage 1: unpack, range check, offsets from the pivot.
  logic                                s1_v_q;
  aasc_pkg::side_t                     s1_q, s1_d;
  logic signed [aasc_pkg::RawW-1:0]    in_raw;
  logic [aasc_pkg::CoordW-1:0]         in_cx, in_cy;

  assign in_raw = $signed(s_axis_tdata[13:0]);
  assign in_cx  = s_axis_tdata[29:14];
  assign in_cy  = s_axis_tdata[45:30];

  always_comb begin
    s1_d       = '0;
    s1_d.op    = aasc_pkg::op_e'(s_axis_tuser[0]);
    s1_d.raw   = in_raw;
    s1_d.px    = in_cx;
    s1_d.py    = in_cy;
    s1_d.dx    = $signed({1'b0, in_cx}) - $signed({1'b0, cx_q});
    s1_d.dy    = $signed({1'b0, in_cy}) - $signed({1'b0, cy_q});
    if (in_raw[aasc_pkg::RawW-1]) begin
      s1_d.fault = aasc_pkg::FAULT_UNDER;
    end else if (in_raw > $signed({1'b0, fs_q})) begin
      s1_d.fault = aasc_pkg::FAULT_OVER;
    end else begin
      s1_d.fault = aasc_pkg::FAULT_NONE;
    end
  end

  // Stage 2: sample times angle span.
  logic                                s2_v_q;
  aasc_pkg::side_t                     s2_q;
  logic signed [31:0]                  s2_prod_q;

  // Stage 3: magnitude plus half the divisor for round-half-away.
  logic                                s3_v_q;
  aasc_pkg::side_t                     s3_q, s3_d;
  logic [N0-1:0]                       s3_num_q;
  logic [aasc_pkg::Div0DenW-1:0]       s3_den_q;
  logic [31:0]                         mag0;

  assign mag0 = s2_prod_q[31] ? 32'(-s2_prod_q) : 32'(s2_prod_q);

  always_comb begin
    s3_d     = s2_q;
    s3_d.neg = s2_prod_q[31];
  end

  // First divider chain.
  logic                                d0_v   [0:N0];
  logic [aasc_pkg::Div0DenW-1:0]       d0_den [0:N0];
  logic [aasc_pkg::Div0DenW-1:0]       d0_rem [0:N0];
  logic [N0-1:0]                       d0_num [0:N0];
  logic [N0-1:0]                       d0_quo [0:N0];
  aasc_pkg::side_t                     d0_sd  [0:N0];

  assign d0_v[0]   = s3_v_q;
  assign d0_den[0] = s3_den_q;
  assign d0_rem[0] = '0;
  assign d0_num[0] = s3_num_q;
  assign d0_quo[0] = '0;
  assign d0_sd[0]  = s3_q;

  for (genvar g = 0; g < N0; g++) begin : g_div0
    aasc_div_cell #(.NumW(N0), .DenW(aasc_pkg::Div0DenW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d0_v[g]),
      .den_i   (d0_den[g]),
      .rem_i   (d0_rem[g]),
      .num_i   (d0_num[g]),
      .quo_i   (d0_quo[g]),
      .side_i  (d0_sd[g]),
      .valid_o (d0_v[g+1]),
      .den_o   (d0_den[g+1]),
      .rem_o   (d0_rem[g+1]),
      .num_o   (d0_num[g+1]),
      .quo_o   (d0_quo[g+1]),
      .side_o  (d0_sd[g+1])
    );
  end

  // Stage 4: angle from the scaled sample, saturated to 17 bits.
  logic                                s4_v_q;
  aasc_pkg::side_t                     s4_q, s4_d;
  logic signed [31:0]                  q0s, a0;

  always_comb begin
    q0s  = $signed({2'b00, d0_quo[N0]});
    a0   = (d0_sd[N0].neg ? -q0s : q0s) + 32'(lo_q);
    s4_d = d0_sd[N0];
    if (a0 < -32'sd65536) begin
      s4_d.ang = -19'sd65536;
    end else if (a0 > 32'sd65535) begin
      s4_d.ang = 19'sd65535;
    end else begin
      s4_d.ang = AW'(a0);
    end
  end

  // Stage 5: CORDIC start vector for both modes.
  logic                                s5_v_q;
  aasc_pkg::side_t                     s5_q, s5_d;
  logic signed [CW-1:0]                s5_x_q, s5_y_q, s5_x_d, s5_y_d;
  logic signed [ZW-1:0]                s5_z_q, s5_z_d, zr, zw;
  logic [43:0]                         len_gain;

  assign len_gain = 44'(len_q) * 44'(aasc_pkg::GainQ30);

  always_comb begin
    s5_d = s4_q;
    zr   = ZW'(s4_q.ang) <<< 8;
    if (zr > aasc_pkg::Deg180) begin
      zw = zr - aasc_pkg::Deg360;
    end else if (zr <= -aasc_pkg::Deg180) begin
      zw = zr + aasc_pkg::Deg360;
    end else begin
      zw = zr;
    end
    if (s4_q.op == aasc_pkg::OP_TO_ANGLE) begin
      s5_d.zero = (s4_q.dx == '0) && (s4_q.dy == '0);
      s5_d.flip = 1'b0;
      if (s4_q.dx[aasc_pkg::DeltaW-1]) begin
        s5_x_d = (-CW'(s4_q.dx)) <<< 12;
        s5_y_d = (-CW'(s4_q.dy)) <<< 12;
        s5_z_d = s4_q.dy[aasc_pkg::DeltaW-1] ? -aasc_pkg::Deg180 : aasc_pkg::Deg180;
      end else begin
        s5_x_d = CW'(s4_q.dx) <<< 12;
        s5_y_d = CW'(s4_q.dy) <<< 12;
        s5_z_d = '0;
      end
    end else begin
      s5_d.zero = 1'b0;
      s5_x_d    = $signed({4'b0000, len_gain[43:16]});
      s5_y_d    = '0;
      if (zw > aasc_pkg::Deg90) begin
        s5_z_d    = zw - aasc_pkg::Deg180;
        s5_d.flip = 1'b1;
      end else if (zw < -aasc_pkg::Deg90) begin
        s5_z_d    = zw + aasc_pkg::Deg180;
        s5_d.flip = 1'b1;
      end else begin
        s5_z_d    = zw;
        s5_d.flip = 1'b0;
      end
    end
  end

  // CORDIC chain.
  logic                                c_v  [0:CORDIC_STAGES];
  logic signed [CW-1:0]                c_x  [0:CORDIC_STAGES];
  logic signed [CW-1:0]                c_y  [0:CORDIC_STAGES];
  logic signed [ZW-1:0]                c_z  [0:CORDIC_STAGES];
  aasc_pkg::side_t                     c_sd [0:CORDIC_STAGES];

  assign c_v[0]  = s5_v_q;
  assign c_x[0]  = s5_x_q;
  assign c_y[0]  = s5_y_q;
  assign c_z[0]  = s5_z_q;
  assign c_sd[0] = s5_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    aasc_cordic_cell #(.Idx(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_v[g]),
      .x_i     (c_x[g]),
      .y_i     (c_y[g]),
      .z_i     (c_z[g]),
      .side_i  (c_sd[g]),
      .valid_o (c_v[g+1]),
      .x_o     (c_x[g+1]),
      .y_o     (c_y[g+1]),
      .z_o     (c_z[g+1]),
      .side_o  (c_sd[g+1])
    );
  end

  // Stage 6: position from the rotated vector, or clamped angle from vectoring.
  logic                                s6_v_q;
  aasc_pkg::side_t                     s6_q, s6_d;
  logic signed [CW-1:0]                xf, yf, tx, ty, pxs, pys;
  logic signed [ZW-1:0]                zrnd;
  logic signed [AW-1:0]                av;

  always_comb begin
    s6_d = c_sd[CORDIC_STAGES];
    xf   = c_sd[CORDIC_STAGES].flip ? -c_x[CORDIC_STAGES] : c_x[CORDIC_STAGES];
    yf   = c_sd[CORDIC_STAGES].flip ? -c_y[CORDIC_STAGES] : c_y[CORDIC_STAGES];
    tx   = (xf + 32'sd8192) >>> 14;
    ty   = (yf + 32'sd8192) >>> 14;
    pxs  = $signed({16'h0000, cx_q}) + tx;
    pys  = $signed({16'h0000, cy_q}) + ty;
    zrnd = c_z[CORDIC_STAGES] + 27'sd128;
    av   = c_sd[CORDIC_STAGES].zero ? '0 : $signed(zrnd[ZW-1:8]);
    if (c_sd[CORDIC_STAGES].op == aasc_pkg::OP_TO_ANGLE) begin
      if (av < lo_x) begin
        av = lo_x;
      end
      if (av > hi_x) begin
        av = hi_x;
      end
      s6_d.ang = av;
    end else begin
      if (pxs < 0) begin
        s6_d.px = '0;
      end else if (pxs > 32'sd65535) begin
        s6_d.px = 16'hFFFF;
      end else begin
        s6_d.px = pxs[15:0];
      end
      if (pys < 0) begin
        s6_d.py = '0;
      end else if (pys > 32'sd65535) begin
        s6_d.py = 16'hFFFF;
      end else begin
        s6_d.py = pys[15:0];
      end
    end
  end

  // Stage 7: angle offset times full scale, and the span.
  logic                                s7_v_q;
  aasc_pkg::side_t                     s7_q;
  logic signed [33:0]                  s7_num_q;
  logic signed [aasc_pkg::LimW-1:0]    s7_den_q;
  logic signed [AW:0]                  adiff;

  assign adiff = (AW+1)'(s6_q.ang) - (AW+1)'(lo_x);

  // Stage 8: magnitudes and sign for the second divider.
  logic                                s8_v_q;
  aasc_pkg::side_t                     s8_q, s8_d;
  logic [aasc_pkg::Div1NumW-1:0]       s8_num_q;
  logic [aasc_pkg::Div1DenW-1:0]       s8_den_q;
  logic [33:0]                         mag1;
  logic [aasc_pkg::LimW-1:0]           magd;

  assign mag1 = s7_num_q[33] ? 34'(-s7_num_q) : 34'(s7_num_q);
  assign magd = s7_den_q[aasc_pkg::LimW-1] ? aasc_pkg::LimW'(-s7_den_q)
                                           : aasc_pkg::LimW'(s7_den_q);

  always_comb begin
    s8_d     = s7_q;
    s8_d.neg = s7_num_q[33] ^ s7_den_q[aasc_pkg::LimW-1];
    s8_d.dz  = (s7_den_q == '0);
  end

  // Second divider chain: the quotient never exceeds full scale, so the upper
  // numerator bits start out as the partial remainder.
  logic                                d1_v   [0:N1];
  logic [aasc_pkg::Div1DenW-1:0]       d1_den [0:N1];
  logic [aasc_pkg::Div1DenW-1:0]       d1_rem [0:N1];
  logic [N1-1:0]                       d1_num [0:N1];
  logic [N1-1:0]                       d1_quo [0:N1];
  aasc_pkg::side_t                     d1_sd  [0:N1];

  assign d1_v[0]   = s8_v_q;
  assign d1_den[0] = s8_den_q;
  assign d1_rem[0] = s8_num_q[aasc_pkg::Div1NumW-1:N1];
  assign d1_num[0] = s8_num_q[N1-1:0];
  assign d1_quo[0] = '0;
  assign d1_sd[0]  = s8_q;

  for (genvar g = 0; g < N1; g++) begin : g_div1
    aasc_div_cell #(.NumW(N1), .DenW(aasc_pkg::Div1DenW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d1_v[g]),
      .den_i   (d1_den[g]),
      .rem_i   (d1_rem[g]),
      .num_i   (d1_num[g]),
      .quo_i   (d1_quo[g]),
      .side_i  (d1_sd[g]),
      .valid_o (d1_v[g+1]),
      .den_o   (d1_den[g+1]),
      .rem_o   (d1_rem[g+1]),
      .num_o   (d1_num[g+1]),
      .quo_o   (d1_quo[g+1]),
      .side_o  (d1_sd[g+1])
    );
  end

  // Output register.
  aasc_pkg::op_e                       out_op_q;
  logic signed [aasc_pkg::RawW-1:0]    out_raw_q, out_raw_d;
  logic signed [aasc_pkg::AngW-1:0]    out_ang_q, out_ang_d;
  logic [aasc_pkg::CoordW-1:0]         out_px_q, out_px_d, out_py_q, out_py_d;
  aasc_pkg::fault_e                    out_fault_q, out_fault_d;
  logic signed [aasc_pkg::RawW-1:0]    r1, q1s;
  aasc_pkg::side_t                     fin;

  assign fin = d1_sd[N1];

  always_comb begin
    q1s = $signed({1'b0, d1_quo[N1]});
    if (fin.dz) begin
      r1 = '0;
    end else begin
      r1 = fin.neg ? -q1s : q1s;
    end
    if (fin.op == aasc_pkg::OP_TO_ANGLE) begin
      out_raw_d = r1;
      out_ang_d = fin.ang[aasc_pkg::AngW-1:0];
      out_px_d  = fin.px;
      out_py_d  = fin.py;
      if (r1[aasc_pkg::RawW-1]) begin
        out_fault_d = aasc_pkg::FAULT_UNDER;
      end else if (r1 > $signed({1'b0, fs_q})) begin
        out_fault_d = aasc_pkg::FAULT_OVER;
      end else begin
        out_fault_d = aasc_pkg::FAULT_NONE;
      end
    end else begin
      out_raw_d   = fin.raw;
      out_fault_d = fin.fault;
      if (fin.fault == aasc_pkg::FAULT_NONE) begin
        out_ang_d = fin.ang[aasc_pkg::AngW-1:0];
        out_px_d  = fin.px;
        out_py_d  = fin.py;
      end else begin
        out_ang_d = '0;
        out_px_d  = cx_q;
        out_py_d  = cy_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= s_axis_tvalid;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= d0_v[N0];
      s5_v_q  <= s4_v_q;
      s6_v_q  <= c_v[CORDIC_STAGES];
      s7_v_q  <= s6_v_q;
      s8_v_q  <= s7_v_q;
      out_v_q <= d1_v[N1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q        <= s1_d;
      s2_q        <= s1_q;
      s2_prod_q   <= 32'(s1_q.raw) * 32'(dlim);
      s3_q        <= s3_d;
      s3_num_q    <= mag0[N0-1:0] + N0'(fs_eff[aasc_pkg::FsW-1:1]);
      s3_den_q    <= fs_eff;
      s4_q        <= s4_d;
      s5_q        <= s5_d;
      s5_x_q      <= s5_x_d;
      s5_y_q      <= s5_y_d;
      s5_z_q      <= s5_z_d;
      s6_q        <= s6_d;
      s7_q        <= s6_q;
      s7_num_q    <= 34'(adiff) * 34'($signed({1'b0, fs_q}));
      s7_den_q    <= dlim;
      s8_q        <= s8_d;
      s8_num_q    <= mag1[aasc_pkg::Div1NumW-1:0];
      s8_den_q    <= magd[aasc_pkg::Div1DenW-1:0];
      out_op_q    <= fin.op;
      out_raw_q   <= out_raw_d;
      out_ang_q   <= out_ang_d;
      out_px_q    <= out_px_d;
      out_py_q    <= out_py_d;
      out_fault_q <= out_fault_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0000000, out_fault_q, out_py_q, out_px_q, out_ang_q, out_raw_q};

  // The preloaded remainder of the second divider must already be below the divisor.
  a_div1_preload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s8_v_q && (s8_q.op == aasc_pkg::OP_TO_ANGLE) && !s8_q.dz |-> d1_rem[0] < d1_den[0])
    else $error("second divider preload exceeds divisor");

  // A clamped angle always maps back inside full scale.
  a_angle_raw_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_op_q == aasc_pkg::OP_TO_ANGLE) |-> out_fault_q == aasc_pkg::FAULT_NONE)
    else $error("angle to raw conversion left full scale");

endmodule

[rtl/core/aasc_div_cell.sv]
module aasc_div_cell #(
  parameter int NumW = 8,
  parameter int DenW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [DenW-1:0]       den_i,
  input  logic [DenW-1:0]       rem_i,
  input  logic [NumW-1:0]       num_i,
  input  logic [NumW-1:0]       quo_i,
  input  aasc_pkg::side_t       side_i,
  output logic                  valid_o,
  output logic [DenW-1:0]       den_o,
  output logic [DenW-1:0]       rem_o,
  output logic [NumW-1:0]       num_o,
  output logic [NumW-1:0]       quo_o,
  output aasc_pkg::side_t       side_o
);

  logic                  valid_q;
  logic [DenW-1:0]       den_q, rem_q, rem_d;
  logic [NumW-1:0]       num_q, quo_q;
  aasc_pkg::side_t       side_q;
  logic [DenW:0]         trial, diff;
  logic                  take;

  // One quotient bit per cell: bring down the next numerator bit and subtract if it fits.
  assign trial = {rem_i, num_i[NumW-1]};
  assign take  = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};
  assign rem_d = take ? diff[DenW-1:0] : trial[DenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      num_q  <= {num_i[NumW-2:0], 1'b0};
      quo_q  <= {quo_i[NumW-2:0], take};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;

endmodule

[rtl/core/aasc_cordic_cell.sv]
module aasc_cordic_cell #(
  parameter int Idx = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [aasc_pkg::CordW-1:0]    x_i,
  input  logic signed [aasc_pkg::CordW-1:0]    y_i,
  input  logic signed [aasc_pkg::ZW-1:0]       z_i,
  input  aasc_pkg::side_t                      side_i,
  output logic                                 valid_o,
  output logic signed [aasc_pkg::CordW-1:0]    x_o,
  output logic signed [aasc_pkg::CordW-1:0]    y_o,
  output logic signed [aasc_pkg::ZW-1:0]       z_o,
  output aasc_pkg::side_t                      side_o
);

  logic                               valid_q;
  logic signed [aasc_pkg::CordW-1:0]  x_q, y_q, xs, ys;
  logic signed [aasc_pkg::ZW-1:0]     z_q, atan;
  aasc_pkg::side_t                    side_q;
  logic                               up;

  assign xs   = x_i >>> Idx;
  assign ys   = y_i >>> Idx;
  assign atan = aasc_pkg::atan_entry(5'(Idx));

  // Rotation steers by the residual angle, vectoring drives y toward zero.
  assign up = (side_i.op == aasc_pkg::OP_TO_ANGLE) ? y_i[aasc_pkg::CordW-1]
                                                    : !z_i[aasc_pkg::ZW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= up ? x_i - ys : x_i + ys;
      y_q    <= up ? y_i + xs : y_i - xs;
      z_q    <= up ? z_i - atan : z_i + atan;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule
